/* rtl/core/bmpd_pkg.sv */
// ----------------------------------------------------------------------------
// bmpd_pkg : shared definitions for the bitmap byte stream decoder
// Result word kinds, header constants and the default dimension width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

  // Default number of bits a width or height may use
  localparam int DIM_BITS_DEFAULT = 16;

  // Kind code of a result word
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Header layout and expected values
  localparam logic [4:0]  HDR_LAST    = 5'd25;
  localparam logic [31:0] HDR_LEN     = 32'd26;
  localparam logic [31:0] CORE_LEN    = 32'd12;
  localparam logic [15:0] PLANES_VAL  = 16'd1;
  localparam logic [15:0] BPP_VAL     = 16'd24;
  localparam logic [7:0]  SIG_FIRST   = 8'h42;  // 'B'
  localparam logic [7:0]  SIG_SECOND  = 8'h4D;  // 'M'

endpackage

`default_nettype wire

/* rtl/core/bmp24_byte_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// bmp24_byte_stream_decoder_core : 24-bit core-header bitmap byte decoder
// Checks the 26-byte header, reports accept or reject, then turns the
// blue/green/red byte triples into pixel words, bottom row first, skipping
// row padding.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  input    | in_valid / in_stall   | data_byte
//  output   | out_valid / out_stall | kind, red, green, blue, column, row,
//           |                       | image_width, image_height, last_pixel
//
//  One byte is taken per cycle while in_stall is low; the decode is a single
//  register-to-register step; its result word appears in the next cycle.
//  A byte causes at most one result word, held in the output register.
//  in_stall is raised only while a result word waits and out_stall is high.
//  rst (synchronous) returns the decoder to the start of a header.
//
`timescale 1ns / 1ps
`default_nettype none

module bmp24_byte_stream_decoder_core #(
  parameter int DIM_BITS = bmpd_pkg::DIM_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [15:0]      column,
  output logic [15:0]      row,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic             last_pixel
);

  import bmpd_pkg::*;

  // Header byte positions that finish a field
  localparam logic [4:0] HB_SIG_B  = 5'd0;
  localparam logic [4:0] HB_SIG_M  = 5'd1;
  localparam logic [4:0] HB_FSIZE  = 5'd5;
  localparam logic [4:0] HB_OFFSET = 5'd13;
  localparam logic [4:0] HB_CORE   = 5'd17;
  localparam logic [4:0] HB_WIDTH  = 5'd19;
  localparam logic [4:0] HB_HEIGHT = 5'd21;
  localparam logic [4:0] HB_PLANES = 5'd23;
  localparam logic [4:0] HB_BPP    = 5'd25;

  // Bits of a 16-bit dimension that may be set; all others must be clear
  localparam logic [15:0] DIM_MASK = 16'((32'd1 << DIM_BITS) - 32'd1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_PAD    = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [4:0]            hdr_count, hdr_count_next;
  logic                  hdr_good, hdr_good_next;
  logic [31:0]           field_acc, field_acc_next;
  logic [15:0]           width_store, width_store_next;
  logic [15:0]           height_store, height_store_next;
  logic [DIM_BITS-1:0]   column_count, column_count_next;
  logic [DIM_BITS-1:0]   current_row, current_row_next;
  logic [1:0]            byte_in_pixel, byte_in_pixel_next;
  logic [7:0]            held_blue, held_blue_next;
  logic [7:0]            held_green, held_green_next;
  logic [1:0]            padding_left, padding_left_next;

  logic                  in_take;
  logic                  res_valid;
  kind_t                 res_kind;
  logic [7:0]            res_red, res_green, res_blue;
  logic [15:0]           res_column, res_row, res_width, res_height;
  logic                  res_last;
  logic                  check_ok;
  logic                  good_upd;
  logic [DIM_BITS-1:0]   column_inc;
  logic                  row_done;

  // Handshake: take a byte unless a result word is stuck
  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;
  assign column_inc = column_count + 1'b1;
  assign row_done   = 16'(column_inc) >= width_store;

  // Next state and result word for the byte on data_byte
  always_comb begin
    phase_next         = phase;
    hdr_count_next     = hdr_count;
    hdr_good_next      = hdr_good;
    field_acc_next     = field_acc;
    width_store_next   = width_store;
    height_store_next  = height_store;
    column_count_next  = column_count;
    current_row_next   = current_row;
    byte_in_pixel_next = byte_in_pixel;
    held_blue_next     = held_blue;
    held_green_next    = held_green;
    padding_left_next  = padding_left;
    res_valid  = 1'b0;
    res_kind   = KIND_ACCEPT;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_column = '0;
    res_row    = '0;
    res_width  = '0;
    res_height = '0;
    res_last   = 1'b0;
    check_ok   = 1'b1;
    good_upd   = hdr_good;

    unique case (phase)
      PH_PIXEL: begin
        unique case (byte_in_pixel)
          2'd0: begin
            held_blue_next     = data_byte;
            byte_in_pixel_next = 2'd1;
          end
          2'd1: begin
            held_green_next    = data_byte;
            byte_in_pixel_next = 2'd2;
          end
          default: begin
            byte_in_pixel_next = 2'd0;
            res_valid  = 1'b1;
            res_kind   = KIND_PIXEL;
            res_red    = data_byte;
            res_green  = held_green;
            res_blue   = held_blue;
            res_column = 16'(column_count);
            res_row    = 16'(current_row);
            column_count_next = column_inc;
            if (row_done) begin
              column_count_next = '0;
              res_last          = (current_row == '0);
              padding_left_next = width_store[1:0];
              if (width_store[1:0] != 2'd0) begin
                phase_next = PH_PAD;
              end else if (current_row == '0) begin
                phase_next     = PH_HEADER;
                hdr_count_next = '0;
                hdr_good_next  = 1'b1;
              end else begin
                current_row_next = current_row - 1'b1;
              end
            end
          end
        endcase
      end

      PH_PAD: begin
        padding_left_next = padding_left - 1'b1;
        if (padding_left == 2'd1) begin
          if (current_row == '0) begin
            phase_next     = PH_HEADER;
            hdr_count_next = '0;
            hdr_good_next  = 1'b1;
          end else begin
            current_row_next = current_row - 1'b1;
            phase_next       = PH_PIXEL;
          end
        end
      end

      // Header phase, also taken by the unused phase code
      default: begin
        phase_next     = PH_HEADER;
        field_acc_next = {data_byte, field_acc[31:8]};
        unique case (hdr_count)
          HB_SIG_B:  check_ok = (data_byte == SIG_FIRST);
          HB_SIG_M:  check_ok = (data_byte == SIG_SECOND);
          HB_FSIZE:  check_ok = (field_acc_next >= HDR_LEN);
          HB_OFFSET: check_ok = (field_acc_next == HDR_LEN);
          HB_CORE:   check_ok = (field_acc_next == CORE_LEN);
          HB_WIDTH:  width_store_next  = field_acc_next[31:16];
          HB_HEIGHT: height_store_next = field_acc_next[31:16];
          HB_PLANES: check_ok = (field_acc_next[31:16] == PLANES_VAL);
          HB_BPP:    check_ok = (field_acc_next[31:16] == BPP_VAL);
          default:   check_ok = 1'b1;
        endcase
        good_upd = hdr_good & check_ok;
        if (hdr_count != HDR_LAST) begin
          hdr_count_next = hdr_count + 1'b1;
          hdr_good_next  = good_upd;
        end else begin
          // Last header byte: verdict
          hdr_count_next = '0;
          hdr_good_next  = 1'b1;
          res_valid      = 1'b1;
          if (good_upd && ((width_store & ~DIM_MASK) == '0)
              && ((height_store & ~DIM_MASK) == '0)) begin
            res_kind   = KIND_ACCEPT;
            res_width  = width_store;
            res_height = height_store;
            if (width_store != '0 && height_store != '0) begin
              phase_next         = PH_PIXEL;
              current_row_next   = DIM_BITS'(height_store - 16'd1);
              column_count_next  = '0;
              byte_in_pixel_next = 2'd0;
              padding_left_next  = 2'd0;
            end
          end else begin
            res_kind = KIND_REJECT;
          end
        end
      end
    endcase
  end

  // Decoder state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hdr_count     <= '0;
      hdr_good      <= 1'b1;
      field_acc     <= '0;
      width_store   <= '0;
      height_store  <= '0;
      column_count  <= '0;
      current_row   <= '0;
      byte_in_pixel <= '0;
      held_blue     <= '0;
      held_green    <= '0;
      padding_left  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_take) begin
        phase         <= phase_next;
        hdr_count     <= hdr_count_next;
        hdr_good      <= hdr_good_next;
        field_acc     <= field_acc_next;
        width_store   <= width_store_next;
        height_store  <= height_store_next;
        column_count  <= column_count_next;
        current_row   <= current_row_next;
        byte_in_pixel <= byte_in_pixel_next;
        held_blue     <= held_blue_next;
        held_green    <= held_green_next;
        padding_left  <= padding_left_next;
      end
      if (in_take) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a word is produced
  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      kind         <= res_kind;
      red          <= res_red;
      green        <= res_green;
      blue         <= res_blue;
      column       <= res_column;
      row          <= res_row;
      image_width  <= res_width;
      image_height <= res_height;
      last_pixel   <= res_last;
    end
  end

  // Checks
  a_reset_to_header: assert property (@(posedge clk)
    rst |=> (phase == PH_HEADER) && (hdr_count == '0) && !out_valid)
    else $error("decoder not at header start after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_last_is_bottom_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> (kind == KIND_PIXEL) && (row == '0))
    else $error("last pixel flag on a word that is not the final pixel");

  a_pixel_byte_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXEL) |-> (byte_in_pixel != 2'd3))
    else $error("byte index within pixel out of range");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : bitmap byte stream decoder check
// Streams 24-bit core-header bitmap files into the decoder a byte at a time:
// a short table of directed headers and images (good headers, each broken
// field, empty images, size extremes), then random well-formed images mixed
// with broken headers and garbage, ending in a cut-off image. A behavioural
// decoder predicts every result word. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;
  import bmpd_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int RANDOM_BYTES  = 200;
  localparam int DIM_W         = DIM_BITS_DEFAULT;
  localparam int ERR_PRINT_MAX = 40;
  localparam int PLAN_ROWS     = 18;

  // offset of the last byte of each checked header field
  localparam logic [4:0] OFS_SIG0   = 5'd0;
  localparam logic [4:0] OFS_SIG1   = 5'd1;
  localparam logic [4:0] OFS_FSIZE  = 5'd5;
  localparam logic [4:0] OFS_OFFSET = 5'd13;
  localparam logic [4:0] OFS_CORE   = 5'd17;
  localparam logic [4:0] OFS_WIDTH  = 5'd19;
  localparam logic [4:0] OFS_HEIGHT = 5'd21;
  localparam logic [4:0] OFS_PLANES = 5'd23;

  typedef enum logic [1:0] {DEC_HEADER, DEC_PIXEL, DEC_PAD} dec_phase_t;
  typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic [7:0]  sig0;
    logic [7:0]  sig1;
    logic [31:0] file_size;
    logic [31:0] reserved;
    logic [31:0] data_offset;
    logic [31:0] core_size;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] planes;
    logic [15:0] bpp;
  } bmp_header_t;

  typedef struct packed {
    bmp_header_t hdr;
    fill_t       fill;
    kind_t       verdict;
    logic        typed;
  } plan_row_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] pix_row;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } bmp_word_t;

  // directed images: header verdict typed in where it is obvious
  plan_row_t plan [PLAN_ROWS] = '{
    // 1x1 at the minimum file size, black pixel
    '{'{SIG_FIRST, SIG_SECOND, 32'd26, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, PLANES_VAL, BPP_VAL}, FILL_ZERO, KIND_ACCEPT, 1'b1},
    // 2x2 at the largest file size, white pixels
    '{'{SIG_FIRST, SIG_SECOND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, HDR_LEN, CORE_LEN,
        16'd2, 16'd2, PLANES_VAL, BPP_VAL}, FILL_ONES, KIND_ACCEPT, 1'b1},
    // bad first signature byte
    '{'{8'h62, SIG_SECOND, 32'd50, 32'd0, HDR_LEN, CORE_LEN,
        16'd3, 16'd2, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // bad second signature byte
    '{'{SIG_FIRST, 8'h00, 32'd50, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // file size one short of the header
    '{'{SIG_FIRST, SIG_SECOND, 32'd25, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // data offset of a full info header
    '{'{SIG_FIRST, SIG_SECOND, 32'd60, 32'd0, 32'd54, CORE_LEN,
        16'd1, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // info header size instead of core
    '{'{SIG_FIRST, SIG_SECOND, 32'd60, 32'd0, HDR_LEN, 32'd40,
        16'd1, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // no planes
    '{'{SIG_FIRST, SIG_SECOND, 32'd60, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, 16'd0, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // two planes
    '{'{SIG_FIRST, SIG_SECOND, 32'd60, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, 16'd2, BPP_VAL}, FILL_RAND, KIND_REJECT, 1'b1},
    // 32 bits per pixel
    '{'{SIG_FIRST, SIG_SECOND, 32'd60, 32'd0, HDR_LEN, CORE_LEN,
        16'd1, 16'd1, PLANES_VAL, 16'd32}, FILL_RAND, KIND_REJECT, 1'b1},
    // empty image, widest possible
    '{'{SIG_FIRST, SIG_SECOND, 32'd26, 32'd0, HDR_LEN, CORE_LEN,
        16'hFFFF, 16'd0, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b1},
    // empty image, tallest possible
    '{'{SIG_FIRST, SIG_SECOND, 32'd26, 32'd0, HDR_LEN, CORE_LEN,
        16'd0, 16'hFFFF, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b1},
    // small images, one for each padding length
    '{'{SIG_FIRST, SIG_SECOND, 32'd62, 32'd0, HDR_LEN, CORE_LEN,
        16'd3, 16'd3, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b0},
    '{'{SIG_FIRST, SIG_SECOND, 32'd58, 32'd0, HDR_LEN, CORE_LEN,
        16'd5, 16'd2, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b0},
    '{'{SIG_FIRST, SIG_SECOND, 32'd46, 32'd0, HDR_LEN, CORE_LEN,
        16'd6, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b0},
    '{'{SIG_FIRST, SIG_SECOND, 32'd62, 32'd0, HDR_LEN, CORE_LEN,
        16'd4, 16'd3, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b0},
    // one long row
    '{'{SIG_FIRST, SIG_SECOND, 32'd806, 32'd0, HDR_LEN, CORE_LEN,
        16'd259, 16'd1, PLANES_VAL, BPP_VAL}, FILL_RAND, KIND_ACCEPT, 1'b0},
    // largest dimensions, but no bits per pixel
    '{'{SIG_FIRST, SIG_SECOND, 32'd26, 32'd0, HDR_LEN, CORE_LEN,
        16'hFFFF, 16'hFFFF, PLANES_VAL, 16'd0}, FILL_RAND, KIND_REJECT, 1'b1}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  red, green, blue;
  logic [15:0] column, row, image_width, image_height;
  logic        last_pixel;

  // byte stream and its per-byte notes, built before reset is released
  logic [7:0] feed_byte [$];
  int         feed_row [$];   // directed row whose header ends here, else -1
  bit         feed_hold [$];  // wait for every word to drain before this byte

  bmp_word_t due_words [$];
  int        cycle_count = 0;
  int        errors      = 0;
  int        words_seen  = 0;
  int        taken       = 0;
  int        stall_left  = 0;
  bit        calm_in     = 1'b0;
  bit        calm_out    = 1'b0;

  // decoder state mirror
  dec_phase_t  dec_phase;
  logic [4:0]  hdr_count;
  logic        hdr_ok;
  logic [31:0] hdr_shift;
  logic [15:0] img_w, img_h, col_next, row_now;
  logic [1:0]  tri_pos, pad_left;
  logic [7:0]  hold_blue, hold_green;

  bmp24_byte_stream_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .column       (column),
    .row          (row),
    .image_width  (image_width),
    .image_height (image_height),
    .last_pixel   (last_pixel)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------- helpers

  task automatic flag_error(input string what);
    errors++;
    if (errors <= ERR_PRINT_MAX) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("word %0d %s: got %0h, expected %0h",
                           words_seen, name, got, want));
  endtask

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) begin
      feed_byte.push_back(v[8*k +: 8]);
      feed_row.push_back(-1);
      feed_hold.push_back(1'b0);
    end
  endfunction

  function automatic void append_header(input bmp_header_t h, input int plan_idx,
                                        input bit hold);
    int first = feed_byte.size();
    push_le(32'(h.sig0), 1);
    push_le(32'(h.sig1), 1);
    push_le(h.file_size, 4);
    push_le(h.reserved, 4);
    push_le(h.data_offset, 4);
    push_le(h.core_size, 4);
    push_le(32'(h.width), 2);
    push_le(32'(h.height), 2);
    push_le(32'(h.planes), 2);
    push_le(32'(h.bpp), 2);
    feed_hold[first] = hold;
    feed_row[feed_row.size() - 1] = plan_idx;
  endfunction

  // pixel triples plus row padding; keep < 0 sends the whole image
  function automatic void append_pixels(input logic [15:0] w, input logic [15:0] h,
                                        input fill_t fill, input int keep);
    int sent = 0;
    int per_row = 3 * int'(w) + int'(w % 4);
    logic [7:0] v;
    for (int y = 0; y < int'(h); y++) begin
      for (int x = 0; x < per_row; x++) begin
        if (sent == keep) return;
        case (fill)
          FILL_ZERO: v = 8'h00;
          FILL_ONES: v = 8'hFF;
          default:   v = 8'($urandom);
        endcase
        push_le(32'(v), 1);
        sent++;
      end
    end
  endfunction

  function automatic bmp_header_t good_header(input logic [15:0] w, input logic [15:0] h);
    bmp_header_t hd;
    hd.sig0        = SIG_FIRST;
    hd.sig1        = SIG_SECOND;
    hd.file_size   = $urandom;
    if (hd.file_size < HDR_LEN) hd.file_size = hd.file_size + HDR_LEN;
    hd.reserved    = $urandom;
    hd.data_offset = HDR_LEN;
    hd.core_size   = CORE_LEN;
    hd.width       = w;
    hd.height      = h;
    hd.planes      = PLANES_VAL;
    hd.bpp         = BPP_VAL;
    return hd;
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void restart_header();
    dec_phase = DEC_HEADER;
    hdr_count = '0;
    hdr_ok    = 1'b1;
  endfunction

  function automatic void decoder_reset();
    restart_header();
    hdr_shift  = '0;
    img_w      = '0;
    img_h      = '0;
    col_next   = '0;
    row_now    = '0;
    tri_pos    = '0;
    hold_blue  = '0;
    hold_green = '0;
    pad_left   = '0;
  endfunction

  // top row done: back to headers, else move up one memory row
  function automatic void finish_row();
    if (row_now == '0) restart_header();
    else begin
      row_now   = row_now - 16'd1;
      dec_phase = DEC_PIXEL;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, output logic made,
                                      output bmp_word_t w);
    made = 1'b0;
    w    = '0;
    case (dec_phase)
      DEC_PIXEL: begin
        if (tri_pos == 2'd0) begin
          hold_blue = b;
          tri_pos   = 2'd1;
        end else if (tri_pos == 2'd1) begin
          hold_green = b;
          tri_pos    = 2'd2;
        end else begin
          tri_pos   = 2'd0;
          made      = 1'b1;
          w.kind    = KIND_PIXEL;
          w.red     = b;
          w.green   = hold_green;
          w.blue    = hold_blue;
          w.column  = col_next;
          w.pix_row = row_now;
          col_next  = col_next + 16'd1;
          if (col_next >= img_w) begin
            col_next = '0;
            w.last   = (row_now == '0);
            pad_left = img_w[1:0];
            if (pad_left != 2'd0) dec_phase = DEC_PAD;
            else finish_row();
          end
        end
      end
      DEC_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) finish_row();
      end
      default: begin
        // header: bytes shift in from the top, little-endian
        dec_phase = DEC_HEADER;
        hdr_shift = {b, hdr_shift[31:8]};
        case (hdr_count)
          OFS_SIG0:   if (b != SIG_FIRST) hdr_ok = 1'b0;
          OFS_SIG1:   if (b != SIG_SECOND) hdr_ok = 1'b0;
          OFS_FSIZE:  if (hdr_shift < HDR_LEN) hdr_ok = 1'b0;
          OFS_OFFSET: if (hdr_shift != HDR_LEN) hdr_ok = 1'b0;
          OFS_CORE:   if (hdr_shift != CORE_LEN) hdr_ok = 1'b0;
          OFS_WIDTH:  img_w = hdr_shift[31:16];
          OFS_HEIGHT: img_h = hdr_shift[31:16];
          OFS_PLANES: if (hdr_shift[31:16] != PLANES_VAL) hdr_ok = 1'b0;
          HDR_LAST:   if (hdr_shift[31:16] != BPP_VAL) hdr_ok = 1'b0;
          default: ;
        endcase
        if (hdr_count != HDR_LAST) hdr_count = hdr_count + 5'd1;
        else begin
          if (((32'(img_w) | 32'(img_h)) >> DIM_W) != 0) hdr_ok = 1'b0;
          made = 1'b1;
          if (hdr_ok) begin
            w.kind   = KIND_ACCEPT;
            w.width  = img_w;
            w.height = img_h;
            restart_header();
            if (img_w != '0 && img_h != '0) begin
              dec_phase = DEC_PIXEL;
              row_now   = img_h - 16'd1;
              col_next  = '0;
              tri_pos   = '0;
              pad_left  = '0;
            end
          end else begin
            w.kind = KIND_REJECT;
            restart_header();
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- monitor

  // check result words, then predict from the byte taken at this edge
  always @(posedge clk) begin : monitor
    logic      made;
    bmp_word_t guess;
    bmp_word_t want;
    int        r;
    if (rst) decoder_reset();
    else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) flag_error("result word with none expected");
        else begin
          want = due_words.pop_front();
          check_field("kind", 32'(kind), 32'(want.kind));
          check_field("red", 32'(red), 32'(want.red));
          check_field("green", 32'(green), 32'(want.green));
          check_field("blue", 32'(blue), 32'(want.blue));
          check_field("column", 32'(column), 32'(want.column));
          check_field("row", 32'(row), 32'(want.pix_row));
          check_field("image_width", 32'(image_width), 32'(want.width));
          check_field("image_height", 32'(image_height), 32'(want.height));
          check_field("last_pixel", 32'(last_pixel), 32'(want.last));
        end
        words_seen++;
      end
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, made, guess);
        r = feed_row[taken];
        if (r >= 0) begin
          // verdict typed into the table wins over the prediction
          made         = 1'b1;
          guess        = '0;
          guess.kind   = plan[r].verdict;
          if (plan[r].verdict == KIND_ACCEPT) begin
            guess.width  = plan[r].hdr.width;
            guess.height = plan[r].hdr.height;
          end
        end
        if (made) due_words.push_back(guess);
        taken++;
      end
    end
  end

  // ---------------------------------------------------------------- back-pressure

  always @(posedge clk) begin : result_stall
    if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = calm_out ? 0 : idle_len();
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAIL bmp24_byte_stream_decoder_core");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int          pick;
    int          rand_start;
    int          gap;
    bit          first;
    logic [15:0] w, h;
    bmp_header_t hd;

    // directed table
    for (int p = 0; p < PLAN_ROWS; p++) begin
      append_header(plan[p].hdr, plan[p].typed ? p : -1, 1'b0);
      if (plan[p].verdict == KIND_ACCEPT)
        append_pixels(plan[p].hdr.width, plan[p].hdr.height, plan[p].fill, -1);
    end

    // random: mostly good images, some broken headers, some garbage headers
    rand_start = feed_byte.size();
    first      = 1'b1;
    while (feed_byte.size() - rand_start < RANDOM_BYTES) begin
      pick = first ? 0 : $urandom_range(0, 99);
      w = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 7));
      if ($urandom_range(0, 15) == 0) w = 16'($urandom_range(8, 24));
      h = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      hd = good_header(w, h);
      if (pick < 70) begin
        append_header(hd, -1, first || ($urandom_range(0, 19) == 0));
        append_pixels(w, h, FILL_RAND, -1);
      end else if (pick < 88) begin
        case ($urandom_range(0, 6))
          0:       hd.sig0 = hd.sig0 ^ 8'($urandom_range(1, 255));
          1:       hd.sig1 = hd.sig1 ^ 8'($urandom_range(1, 255));
          2:       hd.file_size = 32'($urandom_range(0, 25));
          3:       hd.data_offset = hd.data_offset ^ ($urandom | 32'h1);
          4:       hd.core_size = hd.core_size ^ ($urandom | 32'h1);
          5:       hd.planes = hd.planes ^ 16'($urandom_range(1, 65535));
          default: hd.bpp = hd.bpp ^ 16'($urandom_range(1, 65535));
        endcase
        append_header(hd, -1, 1'b0);
      end else begin
        for (int k = 0; k < 26; k++) push_le($urandom, 1);
      end
      first = 1'b0;
    end

    // the stream ends part-way through an image
    append_header(good_header(16'd3, 16'd2), -1, 1'b0);
    append_pixels(16'd3, 16'd2, FILL_RAND, $urandom_range(1, 20));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < feed_byte.size(); i++) begin
      if (feed_hold[i]) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_words.size() != 0) @(negedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 149) == 0) calm_in = !calm_in;
      gap = calm_in ? 0 : idle_len();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= feed_byte[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    // drain, then wait on to catch stray words
    @(negedge clk);
    while (due_words.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) $display("PASS bmp24_byte_stream_decoder_core");
    else $display("FAIL bmp24_byte_stream_decoder_core");
    $finish;
  end

endmodule
